// ----- design/grm_pkg.sv -----
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants of the greedy rectangle merge block: cell and
// result records, controller commands, datapath status and register indexes.
// ----------------------------------------------------------------------------
package grm_pkg;

    localparam int KIND_W     = 8;
    localparam int DIR_W      = 3;
    localparam int LIGHT_W    = 4;
    localparam int POS_W      = 3;
    localparam int SIZE_W     = 4;
    localparam int ATTR_W     = DIR_W + 2 * LIGHT_W;
    localparam int LOAD_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0]  REG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_ACTIVE_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET        = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DIR_W-1:0]   dir;
        logic [LIGHT_W-1:0] sun;
        logic [LIGHT_W-1:0] lamp;
    } cell_t;

    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [KIND_W-1:0]  kind;
        logic [DIR_W-1:0]   dir;
        logic [LIGHT_W-1:0] sun;
        logic [LIGHT_W-1:0] lamp;
        logic               last;
    } rect_t;

    typedef enum logic [2:0] {
        ADDR_LOAD,
        ADDR_SCAN,
        ADDR_RIGHT,
        ADDR_DOWN,
        ADDR_CLEAR
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      load_wr;
        logic      scan_init;
        logic      col_inc;
        logic      row_next;
        logic      seed_load;
        logic      rw_inc;
        logic      dx_clr;
        logic      dx_inc;
        logic      rh_inc;
        logic      emit;
        logic      clear_wr;
        logic      finish;
    } grm_cmd_t;

    typedef struct packed {
        logic load_last;
        logic row_end;
        logic col_end;
        logic right_end;
        logic down_end;
        logic cell_empty;
        logic cell_match;
        logic dx_last;
        logic dy_last;
        logic pend_valid;
        logic out_free;
    } grm_status_t;

endpackage

// ----- design/grm_datapath.sv -----
// ----------------------------------------------------------------------------
// grm_datapath
// Slice mask memories, size registers, scan counters, pending rectangle and
// the output register of the greedy rectangle merge block.
// ----------------------------------------------------------------------------
module grm_datapath #(
    parameter int MAX_WIDTH  = 8,
    parameter int MAX_HEIGHT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [grm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  grm_pkg::cell_t                      cell_in,
    input  grm_pkg::grm_cmd_t                   cmd,
    output grm_pkg::grm_status_t                status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output grm_pkg::rect_t                      out_rect
);
    import grm_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SIZE_W-1:0] MAX_W_C = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_C = SIZE_W'(MAX_HEIGHT);

    logic [KIND_W-1:0]     kind_mem [DEPTH];
    logic [ATTR_W-1:0]     attr_mem [DEPTH];
    logic [KIND_W-1:0]     rd_kind_reg;
    logic [ATTR_W-1:0]     rd_attr_reg;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [LOAD_W-1:0]     pos_reg;
    logic [SIZE_W-1:0]     row_reg;
    logic [SIZE_W-1:0]     col_reg;
    logic [SIZE_W-1:0]     rw_reg;
    logic [SIZE_W-1:0]     rh_reg;
    logic [SIZE_W-1:0]     dx_reg;
    logic [SIZE_W-1:0]     dy_reg;
    cell_t                 seed_reg;
    rect_t                 pend_reg;
    logic                  pend_valid_reg;
    rect_t                 out_reg;
    logic                  out_valid_reg;

    logic [SIZE_W-1:0]     w_eff;
    logic [SIZE_W-1:0]     h_eff;
    logic [LOAD_W-1:0]     total;
    logic [SIZE_W-1:0]     row_sel;
    logic [SIZE_W-1:0]     col_sel;
    logic [LOAD_W-1:0]     addr_full;
    logic [ADDR_W-1:0]     addr;
    logic                  out_free;
    rect_t                 new_rect;
    rect_t                 final_rect;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = SIZE_W'(1);
        end
        else if (width_reg > MAX_W_C)
        begin
            w_eff = MAX_W_C;
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = SIZE_W'(1);
        end
        else if (height_reg > MAX_H_C)
        begin
            h_eff = MAX_H_C;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign total = LOAD_W'(w_eff) * LOAD_W'(h_eff);

    always_comb
    begin
        row_sel = row_reg;
        col_sel = col_reg;
        case (cmd.addr_sel)
            ADDR_RIGHT:
            begin
                col_sel = col_reg + rw_reg;
            end
            ADDR_DOWN:
            begin
                row_sel = row_reg + rh_reg;
                col_sel = col_reg + dx_reg;
            end
            ADDR_CLEAR:
            begin
                row_sel = row_reg + dy_reg;
                col_sel = col_reg + dx_reg;
            end
            default:
            begin
                row_sel = row_reg;
                col_sel = col_reg;
            end
        endcase
        if (cmd.addr_sel == ADDR_LOAD)
        begin
            addr_full = pos_reg;
        end
        else
        begin
            addr_full = LOAD_W'(row_sel) * LOAD_W'(w_eff) + LOAD_W'(col_sel);
        end
    end

    assign addr = addr_full[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            kind_mem[addr] <= cell_in.kind;
        end
        else if (cmd.clear_wr)
        begin
            kind_mem[addr] <= '0;
        end
        rd_kind_reg <= kind_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            attr_mem[addr] <= {cell_in.dir, cell_in.sun, cell_in.lamp};
        end
        rd_attr_reg <= attr_mem[addr];
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        new_rect.valid  = 1'b1;
        new_rect.col    = col_reg[POS_W-1:0];
        new_rect.row    = row_reg[POS_W-1:0];
        new_rect.width  = rw_reg;
        new_rect.height = rh_reg;
        new_rect.kind   = seed_reg.kind;
        new_rect.dir    = seed_reg.dir;
        new_rect.sun    = seed_reg.sun;
        new_rect.lamp   = seed_reg.lamp;
        new_rect.last   = 1'b0;
    end

    always_comb
    begin
        if (pend_valid_reg)
        begin
            final_rect = pend_reg;
        end
        else
        begin
            final_rect = '0;
        end
        final_rect.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= SIZE_RESET;
            height_reg     <= SIZE_RESET;
            pos_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ACTIVE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        pos_reg   <= '0;
                    end
                    REG_ACTIVE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        pos_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.load_wr)
            begin
                pos_reg <= status.load_last ? '0 : pos_reg + LOAD_W'(1);
            end

            if (cmd.scan_init)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                row_reg <= row_reg + SIZE_W'(1);
                col_reg <= '0;
            end
            else if (cmd.col_inc)
            begin
                col_reg <= col_reg + SIZE_W'(1);
            end
            else if (cmd.clear_wr && status.dx_last && status.dy_last)
            begin
                col_reg <= col_reg + rw_reg;
            end

            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((cmd.emit && pend_valid_reg) || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_load)
        begin
            seed_reg <= cell_t'({rd_kind_reg, rd_attr_reg});
            rw_reg   <= SIZE_W'(1);
            rh_reg   <= SIZE_W'(1);
        end
        else
        begin
            if (cmd.rw_inc)
            begin
                rw_reg <= rw_reg + SIZE_W'(1);
            end
            if (cmd.rh_inc)
            begin
                rh_reg <= rh_reg + SIZE_W'(1);
            end
        end

        if (cmd.dx_clr || cmd.emit)
        begin
            dx_reg <= '0;
        end
        else if (cmd.dx_inc)
        begin
            dx_reg <= dx_reg + SIZE_W'(1);
        end
        else if (cmd.clear_wr)
        begin
            dx_reg <= status.dx_last ? '0 : dx_reg + SIZE_W'(1);
        end

        if (cmd.emit)
        begin
            dy_reg <= '0;
        end
        else if (cmd.clear_wr && status.dx_last)
        begin
            dy_reg <= dy_reg + SIZE_W'(1);
        end

        if (cmd.emit)
        begin
            pend_reg <= new_rect;
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
        end
        else if (cmd.finish)
        begin
            out_reg <= final_rect;
        end
    end

    always_comb
    begin
        status.load_last  = (pos_reg + LOAD_W'(1)) == total;
        status.row_end    = row_reg == h_eff;
        status.col_end    = col_reg == w_eff;
        status.right_end  = (col_reg + rw_reg) == w_eff;
        status.down_end   = (row_reg + rh_reg) == h_eff;
        status.cell_empty = rd_kind_reg == '0;
        status.cell_match = (rd_kind_reg != '0) &&
                            ({rd_kind_reg, rd_attr_reg} == seed_reg);
        status.dx_last    = (dx_reg + SIZE_W'(1)) == rw_reg;
        status.dy_last    = (dy_reg + SIZE_W'(1)) == rh_reg;
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_rect  = out_reg;

endmodule

// ----- design/grm_controller.sv -----
// ----------------------------------------------------------------------------
// grm_controller
// State machine that loads the slice, walks the greedy merge one memory read
// at a time and sequences the rectangle clear and the result hand-off.
// ----------------------------------------------------------------------------
module grm_controller (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  grm_pkg::grm_status_t    status,
    output grm_pkg::grm_cmd_t       cmd
);
    import grm_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD      = 11'b000_0000_0001,
        S_SCAN_RD   = 11'b000_0000_0010,
        S_SCAN_CMP  = 11'b000_0000_0100,
        S_RIGHT_RD  = 11'b000_0000_1000,
        S_RIGHT_CMP = 11'b000_0001_0000,
        S_DOWN_CHK  = 11'b000_0010_0000,
        S_DOWN_RD   = 11'b000_0100_0000,
        S_DOWN_CMP  = 11'b000_1000_0000,
        S_EMIT      = 11'b001_0000_0000,
        S_CLEAR     = 11'b010_0000_0000,
        S_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = ADDR_SCAN;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready     = 1'b1;
                cmd.addr_sel = ADDR_LOAD;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (status.load_last)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (status.row_end)
                begin
                    state_next = S_FINISH;
                end
                else if (status.col_end)
                begin
                    cmd.row_next = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (status.cell_empty)
                begin
                    cmd.col_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else
                begin
                    cmd.seed_load = 1'b1;
                    state_next    = S_RIGHT_RD;
                end
            end
            S_RIGHT_RD:
            begin
                cmd.addr_sel = ADDR_RIGHT;
                state_next   = status.right_end ? S_DOWN_CHK : S_RIGHT_CMP;
            end
            S_RIGHT_CMP:
            begin
                if (status.cell_match)
                begin
                    cmd.rw_inc = 1'b1;
                    state_next = S_RIGHT_RD;
                end
                else
                begin
                    state_next = S_DOWN_CHK;
                end
            end
            S_DOWN_CHK:
            begin
                if (status.down_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.dx_clr = 1'b1;
                    state_next = S_DOWN_RD;
                end
            end
            S_DOWN_RD:
            begin
                cmd.addr_sel = ADDR_DOWN;
                state_next   = S_DOWN_CMP;
            end
            S_DOWN_CMP:
            begin
                if (!status.cell_match)
                begin
                    state_next = S_EMIT;
                end
                else if (status.dx_last)
                begin
                    cmd.rh_inc = 1'b1;
                    state_next = S_DOWN_CHK;
                end
                else
                begin
                    cmd.dx_inc = 1'b1;
                    state_next = S_DOWN_RD;
                end
            end
            S_EMIT:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.addr_sel = ADDR_CLEAR;
                cmd.clear_wr = 1'b1;
                if (status.dx_last && status.dy_last)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ----- design/greedy_rectangle_merge_top.sv -----
// ----------------------------------------------------------------------------
// greedy_rectangle_merge_top
// Loads one slice mask of cells and covers its non-empty cells with greedy
// rectangles, one result transfer per rectangle.
//
// Cells arrive on the input channel in raster order, one transfer per cycle,
// active_width * active_height transfers per slice. While the slice is being
// covered the input channel is not ready. The walk reads the mask memory in an
// address state and compares the registered read in a compare state, for each
// cell the scan passes and each cell tried to the right of or below a rectangle;
// it adds a check step per row tried downward, a step per finished scan row, an
// emit step per rectangle and a clear step per covered cell.
// Results leave through an output register and are held one rectangle behind
// the walk so that the final one can carry last_rect; an empty slice gives a
// single transfer with rect_valid low and last_rect high.
// When the receiver stalls, the walk waits at the next rectangle until the
// output register is free, and nothing is lost. The configuration channel is
// always ready; writing either size register restarts the slice load.
// Reset selects an 8 by 8 slice, restarts the load and empties the output.
// ----------------------------------------------------------------------------
module greedy_rectangle_merge_top #(
    parameter int MAX_WIDTH  = 8,
    parameter int MAX_HEIGHT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [grm_pkg::KIND_W-1:0]          cell_kind,
    input  logic [grm_pkg::DIR_W-1:0]           cell_dir,
    input  logic [grm_pkg::LIGHT_W-1:0]         cell_sun,
    input  logic [grm_pkg::LIGHT_W-1:0]         cell_lamp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                rect_valid,
    output logic [grm_pkg::POS_W-1:0]           rect_col,
    output logic [grm_pkg::POS_W-1:0]           rect_row,
    output logic [grm_pkg::SIZE_W-1:0]          rect_width,
    output logic [grm_pkg::SIZE_W-1:0]          rect_height,
    output logic [grm_pkg::KIND_W-1:0]          rect_kind,
    output logic [grm_pkg::DIR_W-1:0]           rect_dir,
    output logic [grm_pkg::LIGHT_W-1:0]         rect_sun,
    output logic [grm_pkg::LIGHT_W-1:0]         rect_lamp,
    output logic                                last_rect
);
    import grm_pkg::*;

    grm_cmd_t    cmd;
    grm_status_t status;
    cell_t       cell_in;
    rect_t       out_rect;

    assign cfg_ready = 1'b1;

    assign cell_in.kind = cell_kind;
    assign cell_in.dir  = cell_dir;
    assign cell_in.sun  = cell_sun;
    assign cell_in.lamp = cell_lamp;

    grm_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    grm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_in   (cell_in),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_rect  (out_rect)
    );

    assign rect_valid  = out_rect.valid;
    assign rect_col    = out_rect.col;
    assign rect_row    = out_rect.row;
    assign rect_width  = out_rect.width;
    assign rect_height = out_rect.height;
    assign rect_kind   = out_rect.kind;
    assign rect_dir    = out_rect.dir;
    assign rect_sun    = out_rect.sun;
    assign rect_lamp   = out_rect.lamp;
    assign last_rect   = out_rect.last;

endmodule

// ----- design/grm_checker.sv -----
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks of the greedy rectangle merge block, bound to the top.
// ----------------------------------------------------------------------------
module grm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                rect_valid,
    input  logic [grm_pkg::POS_W-1:0]           rect_col,
    input  logic [grm_pkg::POS_W-1:0]           rect_row,
    input  logic [grm_pkg::SIZE_W-1:0]          rect_width,
    input  logic [grm_pkg::SIZE_W-1:0]          rect_height,
    input  logic [grm_pkg::KIND_W-1:0]          rect_kind,
    input  logic [grm_pkg::DIR_W-1:0]           rect_dir,
    input  logic [grm_pkg::LIGHT_W-1:0]         rect_sun,
    input  logic [grm_pkg::LIGHT_W-1:0]         rect_lamp,
    input  logic                                last_rect
);
    import grm_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rect_valid) &&
        $stable(rect_col) && $stable(rect_row) && $stable(rect_width) &&
        $stable(rect_height) && $stable(rect_kind) && $stable(rect_dir) &&
        $stable(rect_sun) && $stable(rect_lamp) && $stable(last_rect))
        else $error("result changed while stalled");

    // An empty slice reports a single, final transfer.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rect_valid |-> last_rect)
        else $error("empty-slice result without last_rect");

    // A rectangle always covers at least one non-empty cell.
    a_rect_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rect_valid |-> rect_width != '0 && rect_height != '0 &&
        rect_kind != '0)
        else $error("degenerate rectangle");

    // Cells are not taken while the results of a slice are still coming.
    a_no_load_mid_slice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_rect |-> !in_ready)
        else $error("input ready before the slice was finished");

endmodule

bind greedy_rectangle_merge_top grm_checker u_grm_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for greedy_rectangle_merge_top. Slices of cells are
// loaded in raster order under many width and height settings. A scoreboard
// covers each slice with greedy rectangles and queues the results. Every
// result transfer is compared field by field with the oldest queued one.
// Both channels idle at random. Long output holds, in one phase and at random
// later, back the block up into its input. Registers are written only when the
// block is idle, including part way through a slice load.
// ----------------------------------------------------------------------------
module tb_top;
    import grm_pkg::*;

    localparam int MAX_SIZE      = 8;
    localparam int STORE_DEPTH   = 64;
    localparam int RANDOM_CELLS  = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int GAP_MAX       = 8;
    localparam int TIMEOUT_NS    = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    typedef enum int {
        FILL_RANDOM,
        FILL_BLOCKY,
        FILL_UNIFORM,
        FILL_SPARSE
    } fill_t;

    class merge_scoreboard;
        cell_t                 mask[STORE_DEPTH];
        int unsigned           fill;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        rect_t                 rects_due[$];
        int unsigned           errors;
        int unsigned           cells;
        int unsigned           slices;
        int unsigned           empties;
        int unsigned           rects_checked;

        function new();
            fill          = 0;
            width_reg     = SIZE_RESET;
            height_reg    = SIZE_RESET;
            errors        = 0;
            cells         = 0;
            slices        = 0;
            empties       = 0;
            rects_checked = 0;
        endfunction

        function int unsigned eff_size(logic [CFG_DATA_W-1:0] v);
            if (v < 1) return 1;
            if (v > MAX_SIZE) return MAX_SIZE;
            return v;
        endfunction

        function int unsigned slice_cells();
            return eff_size(width_reg) * eff_size(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ACTIVE_WIDTH) begin
                width_reg = data;
                fill = 0;
            end else if (idx == REG_ACTIVE_HEIGHT) begin
                height_reg = data;
                fill = 0;
            end
        endfunction

        function bit same_face(cell_t seed, cell_t other);
            return other.kind != '0 && other == seed;
        endfunction

        function void take_cell(cell_t c);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned col;
            int unsigned rw;
            int unsigned rh;
            int unsigned made;
            cell_t       seed;
            bit          stop;
            rect_t       rec;
            w = eff_size(width_reg);
            h = eff_size(height_reg);
            cells++;
            if (fill >= w * h) fill = 0;
            mask[fill] = c;
            fill++;
            if (fill < w * h) return;
            fill = 0;
            slices++;
            made = 0;
            for (r = 0; r < h; r++) begin
                col = 0;
                while (col < w) begin
                    seed = mask[r * w + col];
                    if (seed.kind == '0) begin
                        col++;
                        continue;
                    end
                    rw = 1;
                    while (col + rw < w && same_face(seed, mask[r * w + col + rw])) rw++;
                    rh = 1;
                    stop = 1'b0;
                    while (r + rh < h && !stop) begin
                        for (int unsigned dx = 0; dx < rw; dx++) begin
                            if (!same_face(seed, mask[(r + rh) * w + col + dx])) stop = 1'b1;
                        end
                        if (!stop) rh++;
                    end
                    rec        = '0;
                    rec.valid  = 1'b1;
                    rec.col    = col[POS_W-1:0];
                    rec.row    = r[POS_W-1:0];
                    rec.width  = rw[SIZE_W-1:0];
                    rec.height = rh[SIZE_W-1:0];
                    rec.kind   = seed.kind;
                    rec.dir    = seed.dir;
                    rec.sun    = seed.sun;
                    rec.lamp   = seed.lamp;
                    rects_due.push_back(rec);
                    made++;
                    for (int unsigned dy = 0; dy < rh; dy++) begin
                        for (int unsigned dx = 0; dx < rw; dx++) begin
                            mask[(r + dy) * w + col + dx].kind = '0;
                        end
                    end
                    col += rw;
                end
            end
            if (made == 0) begin
                rec      = '0;
                rec.last = 1'b1;
                rects_due.push_back(rec);
                empties++;
            end else begin
                rects_due[rects_due.size() - 1].last = 1'b1;
            end
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got_v);
            if (want != got_v) begin
                errors++;
                $display("%0t: rectangle %0d %s expected %0d, got %0d",
                         $time, rects_checked, name, want, got_v);
            end
        endfunction

        function void check_rect(rect_t got);
            rect_t want;
            if (rects_due.size() == 0) begin
                errors++;
                $display("%0t: rectangle transfer with nothing expected, expected none, got %h",
                         $time, got);
                return;
            end
            want = rects_due.pop_front();
            field_check("rect_valid", want.valid, got.valid);
            field_check("rect_col", want.col, got.col);
            field_check("rect_row", want.row, got.row);
            field_check("rect_width", want.width, got.width);
            field_check("rect_height", want.height, got.height);
            field_check("rect_kind", want.kind, got.kind);
            field_check("rect_dir", want.dir, got.dir);
            field_check("rect_sun", want.sun, got.sun);
            field_check("rect_lamp", want.lamp, got.lamp);
            field_check("last_rect", want.last, got.last);
            rects_checked++;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [KIND_W-1:0]      cell_kind = '0;
    logic [DIR_W-1:0]       cell_dir = '0;
    logic [LIGHT_W-1:0]     cell_sun = '0;
    logic [LIGHT_W-1:0]     cell_lamp = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   rect_valid;
    logic [POS_W-1:0]       rect_col;
    logic [POS_W-1:0]       rect_row;
    logic [SIZE_W-1:0]      rect_width;
    logic [SIZE_W-1:0]      rect_height;
    logic [KIND_W-1:0]      rect_kind;
    logic [DIR_W-1:0]       rect_dir;
    logic [LIGHT_W-1:0]     rect_sun;
    logic [LIGHT_W-1:0]     rect_lamp;
    logic                   last_rect;

    merge_scoreboard sb;
    bit              hold_request = 1'b0;
    int unsigned     cells_sent = 0;
    int unsigned     reg_writes = 0;

    greedy_rectangle_merge_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cell_kind   (cell_kind),
        .cell_dir    (cell_dir),
        .cell_sun    (cell_sun),
        .cell_lamp   (cell_lamp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rect_valid  (rect_valid),
        .rect_col    (rect_col),
        .rect_row    (rect_row),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .rect_kind   (rect_kind),
        .rect_dir    (rect_dir),
        .rect_sun    (rect_sun),
        .rect_lamp   (rect_lamp),
        .last_rect   (last_rect)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic cell_t cell_of(int unsigned kind, int unsigned dir,
                                      int unsigned sun, int unsigned lamp);
        cell_t c;
        c.kind = kind[KIND_W-1:0];
        c.dir  = dir[DIR_W-1:0];
        c.sun  = sun[LIGHT_W-1:0];
        c.lamp = lamp[LIGHT_W-1:0];
        return c;
    endfunction

    function automatic cell_t make_cell(fill_t style, cell_t base);
        cell_t c;
        c = cell_of($urandom, $urandom, $urandom, $urandom);
        case (style)
            FILL_RANDOM: ;
            FILL_BLOCKY:
            begin
                c.kind = KIND_W'($urandom_range(0, 2));
                c.dir  = DIR_W'($urandom_range(0, 1));
                c.sun  = $urandom_range(0, 1) ? 4'hF : 4'h0;
                c.lamp = '0;
            end
            FILL_UNIFORM:
            begin
                if ($urandom_range(0, 7) != 0) c = base;
            end
            FILL_SPARSE:
            begin
                if ($urandom_range(0, 2) == 0) c = base;
                else c.kind = '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return CFG_DATA_W'($urandom_range(1, 4));
        if (roll < 8) return CFG_DATA_W'($urandom_range(5, 8));
        if (roll == 8) return $urandom_range(0, 1) ? 4'd0 : 4'd15;
        return CFG_DATA_W'($urandom_range(9, 14));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cell(cell_t c);
        in_valid  <= 1'b1;
        cell_kind <= c.kind;
        cell_dir  <= c.dir;
        cell_sun  <= c.sun;
        cell_lamp <= c.lamp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_cell(c);
        cells_sent++;
    endtask

    task automatic pause_in(int unsigned cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.rects_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_slice(fill_t style, int unsigned gap_max, int unsigned count);
        cell_t base;
        base      = make_cell(FILL_RANDOM, '0);
        base.kind = KIND_W'($urandom_range(1, 255));
        for (int unsigned i = 0; i < count; i++) begin
            pause_in($urandom_range(0, gap_max));
            send_cell(make_cell(style, base));
        end
    endtask

    initial
    begin : rx
        int unsigned stall_left;
        int unsigned stall_max;
        int unsigned mode_left;
        rect_t       got;
        stall_left = 0;
        stall_max  = 0;
        mode_left  = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got = {rect_valid, rect_col, rect_row, rect_width, rect_height,
                       rect_kind, rect_dir, rect_sun, rect_lamp, last_rect};
                sb.check_rect(got);
                stall_left = $urandom_range(0, stall_max);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin : stim
        byte unsigned          row_kinds[8];
        logic [CFG_DATA_W-1:0] w_reg;
        logic [CFG_DATA_W-1:0] h_reg;
        fill_t                 style;
        int unsigned           slices;
        int unsigned           gap_max;
        int unsigned           random_start;
        int unsigned           phase;
        sb = new();
        row_kinds = '{5, 5, 5, 0, 5, 5, 7, 7};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Part of a slice at the reset size, then a size write restarts the load.
        for (int i = 0; i < 3; i++) begin
            pause_in($urandom_range(0, GAP_MAX));
            send_cell(make_cell(FILL_RANDOM, '0));
        end
        wait_for_results();
        write_reg(REG_ACTIVE_WIDTH, 4'd0);
        write_reg(REG_ACTIVE_HEIGHT, 4'd0);
        send_cell(cell_of(0, 5, 15, 15));
        send_cell(cell_of(255, 7, 15, 15));
        pause_in($urandom_range(0, GAP_MAX));
        send_cell(cell_of(1, 6, 0, 0));
        wait_for_results();

        write_reg(REG_ACTIVE_WIDTH, 4'd15);
        write_reg(REG_ACTIVE_HEIGHT, 4'd1);
        for (int i = 0; i < 8; i++) begin
            send_cell(cell_of(row_kinds[i], 2, 9, (i == 5) ? 3 : 4));
        end
        wait_for_results();

        // Writes to unused indexes must not disturb a load in progress.
        write_reg(REG_ACTIVE_WIDTH, 4'd2);
        write_reg(REG_ACTIVE_HEIGHT, 4'd2);
        send_cell(cell_of(42, 3, 7, 1));
        send_cell(cell_of(42, 3, 7, 1));
        wait_for_results();
        write_reg(REG_UNUSED_LO, 4'd1);
        write_reg(REG_UNUSED_HI, 4'd15);
        send_cell(cell_of(42, 3, 7, 1));
        send_cell(cell_of(42, 3, 7, 1));

        random_start = cells_sent;
        phase = 0;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            wait_for_results();
            w_reg   = pick_size();
            h_reg   = pick_size();
            style   = fill_t'($urandom_range(0, 3));
            slices  = $urandom_range(1, 4);
            gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
            if (phase == 0) begin
                w_reg  = 4'd8;
                h_reg  = 4'd8;
                style  = FILL_RANDOM;
                slices = 1;
            end else if (phase == 1) begin
                w_reg  = 4'd8;
                h_reg  = 4'd8;
                style  = FILL_BLOCKY;
                slices = 1;
            end else if (phase == 2 || $urandom_range(0, 11) == 0) begin
                w_reg  = CFG_DATA_W'($urandom_range(1, 3));
                h_reg  = CFG_DATA_W'($urandom_range(1, 3));
                slices = 4;
                hold_request = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_ACTIVE_WIDTH, w_reg);
                write_reg(REG_ACTIVE_HEIGHT, h_reg);
            end else begin
                write_reg(REG_ACTIVE_HEIGHT, h_reg);
                write_reg(REG_ACTIVE_WIDTH, w_reg);
            end
            for (int unsigned s = 0; s < slices; s++) begin
                send_slice(style, gap_max, sb.slice_cells());
            end
            if ($urandom_range(0, 7) == 0 && sb.slice_cells() > 1) begin
                send_slice(style, gap_max, $urandom_range(1, sb.slice_cells() - 1));
            end
            phase++;
        end

        wait_for_results();
        $display("Run covered %0d cells in %0d slices (%0d empty) over %0d register writes,",
                 sb.cells, sb.slices, sb.empties, reg_writes);
        $display("with %0d rectangle transfers checked.", sb.rects_checked);
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
